[rtl/core/n2e_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2e_pkg
// Shared types, token codes and helper functions of the number-to-words block.
// ----------------------------------------------------------------------------
package n2e_pkg;

	localparam int BinW     = 31;
	localparam int NumDig   = 10;
	localparam int BcdW     = 4 * NumDig;
	localparam int TokW     = 5;
	localparam int NumSlots = 16;
	localparam int GrpSlots = 5;

	localparam logic [TokW-1:0] TOK_ZERO      = 5'd0;
	localparam logic [TokW-1:0] TOK_TEN       = 5'd10;
	localparam logic [TokW-1:0] TOK_TENS_BASE = 5'd18;
	localparam logic [TokW-1:0] TOK_HUNDRED   = 5'd28;
	localparam logic [TokW-1:0] TOK_THOUSAND  = 5'd29;
	localparam logic [TokW-1:0] TOK_MILLION   = 5'd30;
	localparam logic [TokW-1:0] TOK_BILLION   = 5'd31;

	typedef logic [TokW-1:0] tok_t;

	typedef struct packed {
		logic [BcdW-1:0] bcd;
		logic [BinW-1:0] bin;
	} dab_t;

	typedef struct packed {
		tok_t [NumSlots-1:0] tok;
		logic [NumSlots-1:0] present;
	} tokset_t;

	typedef struct packed {
		tok_t [GrpSlots-1:0] tok;
		logic [GrpSlots-1:0] present;
	} grp_t;

	function automatic dab_t dabble_step(dab_t s);
		logic [BcdW-1:0] b;
		b = s.bcd;
		for (int k = 0; k < NumDig; k++) begin
			if (b[4*k +: 4] >= 4'd5) begin
				b[4*k +: 4] = b[4*k +: 4] + 4'd3;
			end
		end
		return dab_t'({b, s.bin} << 1);
	endfunction

	function automatic grp_t group_tokens(logic [3:0] h, logic [3:0] t, logic [3:0] u,
		tok_t scale);
		grp_t g;
		g.tok[0]     = {1'b0, h};
		g.present[0] = (h != 4'd0);
		g.tok[1]     = TOK_HUNDRED;
		g.present[1] = (h != 4'd0);
		if (t >= 4'd2) begin
			g.tok[2]     = TOK_TENS_BASE + {1'b0, t};
			g.present[2] = 1'b1;
		end else begin
			g.tok[2]     = (t != 4'd0) ? (TOK_TEN + {1'b0, u}) : {1'b0, u};
			g.present[2] = (t != 4'd0) || (u != 4'd0);
		end
		g.tok[3]     = {1'b0, u};
		g.present[3] = (t >= 4'd2) && (u != 4'd0);
		g.tok[4]     = scale;
		g.present[4] = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
		return g;
	endfunction

endpackage

[rtl/core/number_to_english_word_tokens.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_english_word_tokens
// Reads a 31-bit unsigned number out as a run of English word tokens.
//
//   Channel   Direction  Payload                          Per item
//   s_axis    in         tdata[30:0] value                1 transfer
//   m_axis    out        tdata[4:0] word, tlast = last    1 to 16 transfers
//
// A number passes four conversion stages, one token stage and the serializer
// register before its first token can leave. The serializer then sends one
// token per cycle while the output is ready, so a number occupies the output
// for 1 to 16 transfers and the output port sets the sustained rate. The
// stages before it keep taking numbers while it works, until each holds one.
// Reset clears the valid bits only. Output stalls back up stage by stage
// through the ready chain and hold every item in place.
// ----------------------------------------------------------------------------
module number_to_english_word_tokens (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [30:0] value, [31] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [4:0] word, [7:5] zero
	output logic        m_axis_tlast
);
	import n2e_pkg::*;

	dab_t    st_in;
	dab_t    st_s1;
	dab_t    st_s2;
	dab_t    st_s3;
	dab_t    st_s4;
	tokset_t set_s5;
	logic    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic    rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_ser;
	tok_t    word;

	assign st_in.bcd     = '0;
	assign st_in.bin     = s_axis_tdata[BinW-1:0];
	assign s_axis_tready = rdy_s1;

	n2e_bcd_stage #(.STEPS(8)) u_bcd1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(rdy_s1), .in_st(st_in),
		.out_valid(vld_s1), .out_ready(rdy_s2), .out_st(st_s1)
	);

	n2e_bcd_stage #(.STEPS(8)) u_bcd2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s1), .in_ready(rdy_s2), .in_st(st_s1),
		.out_valid(vld_s2), .out_ready(rdy_s3), .out_st(st_s2)
	);

	n2e_bcd_stage #(.STEPS(8)) u_bcd3 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s2), .in_ready(rdy_s3), .in_st(st_s2),
		.out_valid(vld_s3), .out_ready(rdy_s4), .out_st(st_s3)
	);

	n2e_bcd_stage #(.STEPS(BinW - 24)) u_bcd4 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s3), .in_ready(rdy_s4), .in_st(st_s3),
		.out_valid(vld_s4), .out_ready(rdy_s5), .out_st(st_s4)
	);

	n2e_token_map u_map (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s4), .in_ready(rdy_s5), .in_st(st_s4),
		.out_valid(vld_s5), .out_ready(rdy_ser), .out_set(set_s5)
	);

	n2e_serializer u_ser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s5), .in_ready(rdy_ser), .in_set(set_s5),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.word(word), .last(m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, word};

endmodule

[rtl/core/n2e_bcd_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2e_bcd_stage
// One registered pipeline stage of the binary-to-decimal shift-and-add-three
// conversion, running a fixed number of steps.
// ----------------------------------------------------------------------------
module n2e_bcd_stage #(
	parameter int STEPS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  n2e_pkg::dab_t in_st,
	output logic          out_valid,
	input  logic          out_ready,
	output n2e_pkg::dab_t out_st
);
	import n2e_pkg::*;

	logic vld_q;
	dab_t st_q;
	dab_t nxt;

	always_comb begin
		nxt = in_st;
		for (int i = 0; i < STEPS; i++) begin
			nxt = dabble_step(nxt);
		end
	end

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_st    = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			st_q <= nxt;
		end
	end

endmodule

[rtl/core/n2e_token_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2e_token_map
// Registered stage that turns ten decimal digits into sixteen fixed token
// slots, each with a present bit, in reading order.
// ----------------------------------------------------------------------------
module n2e_token_map (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  n2e_pkg::dab_t    in_st,
	output logic             out_valid,
	input  logic             out_ready,
	output n2e_pkg::tokset_t out_set
);
	import n2e_pkg::*;

	logic            vld_q;
	tokset_t         set_q;
	tokset_t         nxt;
	logic [BcdW-1:0] d;
	grp_t            g_mil;
	grp_t            g_tho;
	grp_t            g_uni;

	always_comb begin
		d     = in_st.bcd;
		g_mil = group_tokens(d[35:32], d[31:28], d[27:24], TOK_MILLION);
		g_tho = group_tokens(d[23:20], d[19:16], d[15:12], TOK_THOUSAND);
		g_uni = group_tokens(d[11:8], d[7:4], d[3:0], TOK_ZERO);

		nxt.tok[0]     = {1'b0, d[39:36]};
		nxt.present[0] = (d[39:36] != 4'd0) || (d == '0);
		nxt.tok[1]     = TOK_BILLION;
		nxt.present[1] = (d[39:36] != 4'd0);
		for (int k = 0; k < GrpSlots; k++) begin
			nxt.tok[2 + k]     = g_mil.tok[k];
			nxt.present[2 + k] = g_mil.present[k];
			nxt.tok[7 + k]     = g_tho.tok[k];
			nxt.present[7 + k] = g_tho.present[k];
		end
		for (int k = 0; k < GrpSlots - 1; k++) begin
			nxt.tok[12 + k]     = g_uni.tok[k];
			nxt.present[12 + k] = g_uni.present[k];
		end
	end

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_set   = set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			set_q <= nxt;
		end
	end

endmodule

[rtl/core/n2e_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2e_serializer
// Holds one number's token slots and sends the present ones out, one per
// transfer, lowest slot first, marking the final one.
// ----------------------------------------------------------------------------
module n2e_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  n2e_pkg::tokset_t in_set,
	output logic             out_valid,
	input  logic             out_ready,
	output n2e_pkg::tok_t    word,
	output logic             last
);
	import n2e_pkg::*;

	logic [NumSlots-1:0]         mask_q;
	tok_t [NumSlots-1:0]         tok_q;
	logic [$clog2(NumSlots)-1:0] idx;
	logic                        single;

	always_comb begin
		idx = '0;
		for (int i = NumSlots - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = i[$clog2(NumSlots)-1:0];
			end
		end
	end

	assign single    = ((mask_q & (mask_q - 1'b1)) == '0);
	assign out_valid = (mask_q != '0);
	assign word      = tok_q[idx];
	assign last      = single;
	assign in_ready  = (mask_q == '0) || (out_ready && single);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (in_valid && in_ready) begin
			mask_q <= in_set.present;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_q <= in_set.tok;
		end
	end

endmodule
